FILE: hw/rtl/lrcr_pkg.sv
package lrcr_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;

  localparam int CH_W      = 4;
  localparam int PHASE_W   = FRAC_BITS + 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = PHASE_W;
  localparam int CNT_W     = $clog2(MAX_CHANNELS + 1);
  localparam int SEL_W     = $clog2(MAX_CHANNELS);

  localparam int MAX_RESULTS = 8;

  // channel sum, rounding offset included
  localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_CHANNELS) + 1;
  // exact floor(a / d) as (a * RECIP[d]) >> RECIP_K for a < 2^SUM_W, d <= 8
  localparam int RECIP_K  = SUM_W + 3;
  localparam int RECIP_W  = RECIP_K + 1;
  localparam int DPROD_W  = SUM_W + RECIP_W;

  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int LPROD_W  = DIFF_W + FRAC_BITS + 1;

  localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] MIN_STEP  = PHASE_W'(1) << (FRAC_BITS - 3);

  localparam logic [CH_W-1:0]    SRC_RESET  = CH_W'(2);
  localparam logic [CH_W-1:0]    DST_RESET  = CH_W'(2);
  localparam logic [PHASE_W-1:0] STEP_RESET = ONE_PHASE;

  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_K;

  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:MAX_CHANNELS] = '{
    RECIP_W'(0),
    RECIP_W'((RECIP_ONE + 64'd0) / 64'd1),
    RECIP_W'((RECIP_ONE + 64'd1) / 64'd2),
    RECIP_W'((RECIP_ONE + 64'd2) / 64'd3),
    RECIP_W'((RECIP_ONE + 64'd3) / 64'd4),
    RECIP_W'((RECIP_ONE + 64'd4) / 64'd5),
    RECIP_W'((RECIP_ONE + 64'd5) / 64'd6),
    RECIP_W'((RECIP_ONE + 64'd6) / 64'd7),
    RECIP_W'((RECIP_ONE + 64'd7) / 64'd8)
  };

  // source lane feeding each output lane when sources repeat, by source count
  localparam logic [SEL_W-1:0] SRC_SEL [0:MAX_CHANNELS][0:MAX_CHANNELS-1] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}
  };

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_CHANNELS = 2'd0,
    REG_DST_CHANNELS = 2'd1,
    REG_PHASE_STEP   = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_REMIX,
    ST_CHECK,
    ST_MULT,
    ST_OUT,
    ST_HOLD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic abs;
    logic div;
    logic remix;
    logic mult;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more;
  } status_t;

endpackage

FILE: hw/rtl/lrcr_ctrl.sv
module lrcr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lrcr_pkg::status_t status,
  output lrcr_pkg::cmd_t    cmd
);
  import lrcr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.abs    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_REMIX;
      end
      ST_REMIX: begin
        cmd.remix  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.more ? ST_MULT : ST_FINISH;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit   = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lrcr_datapath.sv
module lrcr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lrcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrcr_pkg::CFG_W-1:0]         cfg_data,
  input  lrcr_pkg::sample_t                  in_data [lrcr_pkg::MAX_CHANNELS],
  input  lrcr_pkg::cmd_t                     cmd,
  output lrcr_pkg::status_t                  status,
  output lrcr_pkg::sample_t                  out_data [lrcr_pkg::MAX_CHANNELS],
  output logic                               out_last
);
  import lrcr_pkg::*;

  logic [CH_W-1:0]    src_channels;
  logic [CH_W-1:0]    dst_channels;
  logic [PHASE_W-1:0] phase_step;

  logic [CH_W-1:0]    sc;
  logic [CH_W-1:0]    dc;
  logic [PHASE_W-1:0] step_eff;

  sample_t inr   [MAX_CHANNELS];
  sample_t cur   [MAX_CHANNELS];
  sample_t prev  [MAX_CHANNELS];
  sample_t cur_next [MAX_CHANNELS];
  logic signed [LPROD_W-1:0] lane_prod [MAX_CHANNELS];

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] msum;
  logic                    neg;
  logic [SUM_W-1:0]        a_val;
  logic [DPROD_W-1:0]      prod_div;
  logic [SUM_W-1:0]        quot;
  logic signed [SUM_W-1:0] avg_full;
  sample_t                 avg;

  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_sum;
  logic                      history_valid;
  logic [CNT_W-1:0]          count;
  logic signed [FRAC_BITS:0] mult_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_channels <= SRC_RESET;
      dst_channels <= DST_RESET;
      phase_step   <= STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_CHANNELS: src_channels <= cfg_data[CH_W-1:0];
        REG_DST_CHANNELS: dst_channels <= cfg_data[CH_W-1:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_channels == '0) begin
      sc = CH_W'(1);
    end else if (src_channels > CH_W'(MAX_CHANNELS)) begin
      sc = CH_W'(MAX_CHANNELS);
    end else begin
      sc = src_channels;
    end
    if (dst_channels == '0) begin
      dc = CH_W'(1);
    end else if (dst_channels > CH_W'(MAX_CHANNELS)) begin
      dc = CH_W'(MAX_CHANNELS);
    end else begin
      dc = dst_channels;
    end
    step_eff = (phase_step < MIN_STEP) ? MIN_STEP : phase_step;
  end

  // average path: sum, magnitude, reciprocal multiply
  always_comb begin
    sum = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CH_W'(c) < sc) begin
        sum = sum + SUM_W'(inr[c]);
      end
    end
  end

  assign quot     = prod_div[RECIP_K +: SUM_W];
  assign avg_full = neg ? -signed'(quot) : signed'(quot);
  assign avg      = avg_full[SAMPLE_BITS-1:0];

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      cur_next[c] = '0;
      if (CH_W'(c) < dc) begin
        if (sc <= dc) begin
          cur_next[c] = inr[SRC_SEL[sc][c]];
        end else begin
          cur_next[c] = avg;
        end
      end
    end
  end

  assign mult_phase  = signed'({1'b0, phase[FRAC_BITS-1:0]});
  assign phase_sum   = phase + step_eff;
  assign status.more = (phase < ONE_PHASE) && (count != CNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inr <= in_data;
    end
    if (cmd.sum) begin
      msum <= sum + SUM_W'(sc >> 1);
    end
    if (cmd.abs) begin
      neg   <= msum[SUM_W-1];
      a_val <= msum[SUM_W-1] ? (SUM_W'(-msum) + SUM_W'(sc) - SUM_W'(1)) : SUM_W'(msum);
    end
    if (cmd.div) begin
      prod_div <= DPROD_W'(a_val) * DPROD_W'(RECIP_TABLE[sc]);
    end
    if (cmd.remix) begin
      cur <= cur_next;
    end
    if (cmd.mult) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        lane_prod[c] <= (DIFF_W'(cur[c]) - DIFF_W'(prev[c])) * mult_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [LPROD_W-1:0] rnd;
    logic signed [LPROD_W-1:0] term;
    if (cmd.emit) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        rnd  = lane_prod[c] + signed'(LPROD_W'(1) << (FRAC_BITS - 1));
        term = rnd >>> FRAC_BITS;
        if (CH_W'(c) < dc) begin
          out_data[c] <= prev[c] + term[SAMPLE_BITS-1:0];
        end else begin
          out_data[c] <= '0;
        end
      end
      out_last <= (phase_sum >= ONE_PHASE) || (count == CNT_W'(MAX_RESULTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      history_valid <= 1'b0;
      count         <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        prev[c] <= '0;
      end
    end else begin
      if (cmd.remix && !history_valid) begin
        prev <= cur_next;
      end
      if (cmd.emit) begin
        phase <= phase_sum;
        count <= count + CNT_W'(1);
      end
      if (cmd.finish) begin
        phase         <= phase - ONE_PHASE;
        prev          <= cur;
        history_valid <= 1'b1;
        count         <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/linear_resampler_channel_remix.sv
// Linear-interpolation rate converter with channel remix.
// Input channel: in_valid/in_stall carry one frame (in_0..in_7, packet_end).
// The frame is remapped to dst_channels channels (copy, repeat modulo the
// source count, or a rounded average of all sources), then interpolated
// against the previous remixed frame at each phase below 1.0.
// Output channel: out_valid/out_stall carry 0 to 8 frames per input frame,
// out_0..out_7 plus last on the final frame of that input.
// Timing: an input transfer is followed by the remix steps (sum, magnitude,
// reciprocal multiply, select, phase check); each output frame then passes
// through lane multiply, round/add, present and phase check, and is held in
// present while the receiver stalls; a closing step updates phase and
// history. The single-item sequencer takes no new input frame until it is
// through with the current one, and the eight lane multipliers are shared
// across results. in_stall stays high until all results of the current frame
// have transferred. A stalled output frame holds its payload unchanged.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong only in idle periods. Reset clears history, phase and the
// result count and restores 2 source, 2 destination channels, step 1.0.
module linear_resampler_channel_remix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lrcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrcr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [23:0]             in_0,
  input  logic signed [23:0]             in_1,
  input  logic signed [23:0]             in_2,
  input  logic signed [23:0]             in_3,
  input  logic signed [23:0]             in_4,
  input  logic signed [23:0]             in_5,
  input  logic signed [23:0]             in_6,
  input  logic signed [23:0]             in_7,
  input  logic                           packet_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [23:0]             out_0,
  output logic signed [23:0]             out_1,
  output logic signed [23:0]             out_2,
  output logic signed [23:0]             out_3,
  output logic signed [23:0]             out_4,
  output logic signed [23:0]             out_5,
  output logic signed [23:0]             out_6,
  output logic signed [23:0]             out_7,
  output logic                           last
);
  import lrcr_pkg::*;

  cmd_t    cmd;
  status_t status;
  sample_t in_data  [MAX_CHANNELS];
  sample_t out_data [MAX_CHANNELS];

  // packet_end does not affect results
  assign in_data[0] = in_0;
  assign in_data[1] = in_1;
  assign in_data[2] = in_2;
  assign in_data[3] = in_3;
  assign in_data[4] = in_4;
  assign in_data[5] = in_5;
  assign in_data[6] = in_6;
  assign in_data[7] = in_7;

  assign out_0 = out_data[0];
  assign out_1 = out_data[1];
  assign out_2 = out_data[2];
  assign out_3 = out_data[3];
  assign out_4 = out_data[4];
  assign out_5 = out_data[5];
  assign out_6 = out_data[6];
  assign out_7 = out_data[7];

  lrcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lrcr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_last  (last)
  );

endmodule

FILE: tb/linear_resampler_channel_remix_test.sv
module linear_resampler_channel_remix_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrcr_pkg::*;

  localparam int LANES = MAX_CHANNELS;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 4000;
  localparam int RANDOM_FRAMES = 455;
  localparam int MODE_SPAN = 175;
  localparam logic [CFG_W-1:0] MAX_STEP = CFG_W'(524288);
  localparam logic [SAMPLE_BITS-1:0] FULL_POS = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] FULL_NEG = 24'h800000;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lanes_t;
  typedef struct packed {
    lanes_t lane;
    logic   packet_end;
  } frame_t;
  typedef struct packed {
    lanes_t lane;
    logic   last;
  } result_t;

  // Predicts the interpolated output frames and checks them in order.
  class remix_tracker;
    longint held[LANES];
    logic [PHASE_W-1:0] read_pos;
    bit seeded;
    logic [CH_W-1:0] src_count;
    logic [CH_W-1:0] dst_count;
    logic [PHASE_W-1:0] step;
    result_t expected_frames[$];
    int failures;

    function new();
      foreach (held[c]) held[c] = 0;
      read_pos = '0;
      seeded = 1'b0;
      src_count = SRC_RESET;
      dst_count = DST_RESET;
      step = STEP_RESET;
      failures = 0;
    endfunction

    function longint widen(logic [SAMPLE_BITS-1:0] v);
      return longint'($signed(v));
    endfunction

    function longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if (num % den != 0 && num < 0) q -= 1;
      return q;
    endfunction

    function int clamp_count(logic [CH_W-1:0] c);
      if (c == 0) return 1;
      if (c > LANES) return LANES;
      return int'(c);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SRC_CHANNELS: src_count = data[CH_W-1:0];
        REG_DST_CHANNELS: dst_count = data[CH_W-1:0];
        REG_PHASE_STEP: step = data[PHASE_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_frame(frame_t f);
      longint cur[LANES];
      longint sum;
      longint avg;
      longint d;
      int sc;
      int dc;
      int n;
      logic [PHASE_W-1:0] inc;
      result_t r;
      sc = clamp_count(src_count);
      dc = clamp_count(dst_count);
      inc = (step < MIN_STEP) ? MIN_STEP : step;
      foreach (cur[c]) cur[c] = 0;
      if (sc <= dc) begin
        for (int c = 0; c < dc; c++) cur[c] = widen(f.lane[c % sc]);
      end else begin
        sum = 0;
        for (int c = 0; c < sc; c++) sum += widen(f.lane[c]);
        avg = floor_quot(2 * sum + sc, 2 * sc);
        for (int c = 0; c < dc; c++) cur[c] = avg;
      end
      if (!seeded) begin
        held = cur;
        seeded = 1'b1;
      end
      n = 0;
      while (read_pos < ONE_PHASE && n < MAX_RESULTS) begin
        r = '0;
        for (int c = 0; c < dc; c++) begin
          d = cur[c] - held[c];
          r.lane[c] = SAMPLE_BITS'(held[c] + floor_quot(d * longint'(read_pos)
                      + longint'(ONE_PHASE >> 1), longint'(ONE_PHASE)));
        end
        read_pos = read_pos + inc;
        n++;
        r.last = (read_pos >= ONE_PHASE || n == MAX_RESULTS);
        expected_frames = {expected_frames, r};
      end
      read_pos = read_pos - ONE_PHASE;
      held = cur;
    endfunction

    function void mismatch(string field, logic [SAMPLE_BITS-1:0] want,
                           logic [SAMPLE_BITS-1:0] got);
      if (failures < 10) $display("%s: expected %h, got %h", field, want, got);
      failures++;
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        if (failures < 10) $display("output transfer with nothing pending: %h", got);
        failures++;
        return;
      end
      want = expected_frames.pop_front();
      for (int c = 0; c < LANES; c++) begin
        if (got.lane[c] !== want.lane[c])
          mismatch($sformatf("out_%0d", c), want.lane[c], got.lane[c]);
      end
      if (got.last !== want.last)
        mismatch("last", SAMPLE_BITS'(want.last), SAMPLE_BITS'(got.last));
    endfunction

    function void check_leftover();
      if (expected_frames.size() != 0) begin
        if (failures < 10) $display("%0d output frames never arrived", expected_frames.size());
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  lanes_t in_lanes = '0;
  logic packet_end = 1'b0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire last;
  wire lanes_t out_lanes;

  int tx_idle_pct = 13;
  int rx_idle_pct = 58;
  int sent_frames = 0;
  remix_tracker tracker = new();

  linear_resampler_channel_remix uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_0(in_lanes[0]),
    .in_1(in_lanes[1]),
    .in_2(in_lanes[2]),
    .in_3(in_lanes[3]),
    .in_4(in_lanes[4]),
    .in_5(in_lanes[5]),
    .in_6(in_lanes[6]),
    .in_7(in_lanes[7]),
    .packet_end(packet_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_0(out_lanes[0]),
    .out_1(out_lanes[1]),
    .out_2(out_lanes[2]),
    .out_3(out_lanes[3]),
    .out_4(out_lanes[4]),
    .out_5(out_lanes[5]),
    .out_6(out_lanes[6]),
    .out_7(out_lanes[7]),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_output({out_lanes, last});
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return SAMPLE_BITS'(int'($urandom_range(16)) - 8);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < LANES; c++) f.lane[c] = pick_sample();
    f.packet_end = 1'($urandom_range(1));
    return f;
  endfunction

  function automatic frame_t flat_frame(logic [SAMPLE_BITS-1:0] v, logic pe);
    frame_t f;
    for (int c = 0; c < LANES; c++) f.lane[c] = v;
    f.packet_end = pe;
    return f;
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'($urandom_range(9, 15));
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_step();
    case ($urandom_range(9))
      0: return CFG_W'(MIN_STEP);
      1: return MAX_STEP;
      2: return CFG_W'($urandom_range(0, 8191));
      3: return CFG_W'($urandom_range(524289, 20'hFFFFF));
      default: return CFG_W'($urandom_range(8192, 524288));
    endcase
  endfunction

  task automatic send_frame(frame_t f);
    if (sent_frames >= 2 * MODE_SPAN) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (sent_frames >= MODE_SPAN) begin
      tx_idle_pct = 58;
      rx_idle_pct = 13;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lanes <= f.lane;
    packet_end <= f.packet_end;
    do @(posedge clk); while (in_stall);
    tracker.accept_frame(f);
    sent_frames++;
  endtask

  // frames that yield no output keep the block busy after the last transfer
  task automatic settle();
    in_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && tracker.expected_frames.size() != 0; i++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] src, logic [CFG_W-1:0] dst,
                           logic [CFG_W-1:0] inc);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_SRC_CHANNELS;
    cfg_data <= src;
    @(posedge clk);
    cfg_index <= REG_DST_CHANNELS;
    cfg_data <= dst;
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= inc;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(REG_SRC_CHANNELS, src);
    tracker.set_reg(REG_DST_CHANNELS, dst);
    tracker.set_reg(REG_PHASE_STEP, inc);
  endtask

  initial begin
    int random_sent;
    int burst;
    frame_t f;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setting: first frame seeds history, unused source lanes ignored
    send_frame(flat_frame(FULL_POS, 1'b0));
    send_frame(flat_frame(FULL_NEG, 1'b1));
    send_frame(frame_t'({{4{24'h555555, 24'hAAAAAA}}, 1'b0}));
    send_frame(flat_frame('0, 1'b1));

    // mono to eight lanes at the smallest step: eight frames per transfer
    configure(CFG_W'(1), CFG_W'(8), CFG_W'(MIN_STEP));
    f = flat_frame(FULL_NEG, 1'b0);
    f.lane[0] = FULL_POS;
    send_frame(f);
    f = flat_frame(FULL_POS, 1'b1);
    f.lane[0] = FULL_NEG;
    send_frame(f);
    send_frame(random_frame());

    // eight to one average at a step of 8.0, rounding ties
    configure(CFG_W'(8), CFG_W'(1), MAX_STEP);
    send_frame(flat_frame(FULL_POS, 1'b0));
    send_frame(flat_frame(FULL_NEG, 1'b0));
    send_frame(frame_t'({{4{24'h000001}}, {4{24'h000000}}, 1'b1}));
    send_frame(frame_t'({{4{24'hFFFFFF}}, {4{24'h000000}}, 1'b0}));

    // out of range counts, zero and oversized steps, then two in-range remixes
    configure('0, CFG_W'(15), '0);
    repeat (3) send_frame(random_frame());
    configure(CFG_W'(9), '0, 20'hFFFFF);
    repeat (3) send_frame(random_frame());
    configure(CFG_W'(3), CFG_W'(5), CFG_W'(98304));
    repeat (3) send_frame(random_frame());
    configure(CFG_W'(7), CFG_W'(3), CFG_W'(45000));
    repeat (3) send_frame(random_frame());

    while (random_sent < RANDOM_FRAMES) begin
      configure(pick_count(), pick_count(), pick_step());
      burst = $urandom_range(15, 50);
      repeat (burst) send_frame(random_frame());
      random_sent += burst;
    end

    settle();
    tracker.check_leftover();
    if (tracker.failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
